/* rtl/ufifo_pkg.sv */
// Shared types and codes for the unique value FIFO.
package ufifo_pkg;

   localparam int DEPTH   = 16;
   localparam int VALUE_W = 32;
   localparam int OCC_W   = $clog2(DEPTH + 1);

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_DUP   = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  popped_value;
      logic [OCC_W-1:0]           occupancy;
   } rsp_type;

endpackage

/* rtl/ufifo_ram.sv */
// Entry store: one write port, one read port with registered read data.
module ufifo_ram #(
   parameter int DEPTH = 16,
   parameter int PTR_W = 4
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [PTR_W-1:0]                     wr_addr,
   input  logic signed [ufifo_pkg::VALUE_W-1:0] wr_data,
   input  logic [PTR_W-1:0]                     rd_addr,
   output logic signed [ufifo_pkg::VALUE_W-1:0] rd_data
);

   logic signed [ufifo_pkg::VALUE_W-1:0] mem [DEPTH];
   logic signed [ufifo_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/unique_value_fifo.sv */
// Top level of the unique value FIFO: sequencer, pointers and response register.
//
//   channel   direction  ports                               transaction
//   req       in         req_valid, req_stall, req_payload   one push or pop
//   rsp       out        rsp_valid, rsp_stall, rsp_payload   status, value, occupancy
//
// A push accepts the request, makes one compare per held entry against the store's
// registered read data, then writes and loads the response; a duplicate ends the
// walk early and an empty queue skips it. A pop accepts, reads the head and commits;
// a pop on an empty queue skips the head read.
// Reset clears pointers, count, sequencer and response valid, but not the store.
// A stalled response holds in its register; the next transaction waits in its final step.
module unique_value_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ufifo_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ufifo_pkg::rsp_type  rsp_payload
);

   localparam int DEPTH = ufifo_pkg::DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   // Sequencer and pointer state
   ufifo_pkg::state_type   state_ff, state_in;
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [PTR_W-1:0]       scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]       left_ff, left_in;

   // Latched transaction and its outcome
   ufifo_pkg::op_type                    op_ff, op_in;
   logic signed [ufifo_pkg::VALUE_W-1:0] value_ff, value_in;
   ufifo_pkg::status_type                status_ff, status_in;
   logic signed [ufifo_pkg::VALUE_W-1:0] popped_ff, popped_in;

   // Response register
   logic                 rsp_valid_ff, rsp_valid_in;
   ufifo_pkg::rsp_type   rsp_ff, rsp_in;

   // Store ports
   logic                                 wr_en;
   logic [PTR_W-1:0]                     rd_addr;
   logic signed [ufifo_pkg::VALUE_W-1:0] rd_data;

   logic req_take;
   logic out_free;
   logic match;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] idx);
      next_slot = (idx == LAST_SLOT) ? '0 : idx + PTR_W'(1);
   endfunction

   assign req_stall = (state_ff != ufifo_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign match     = (rd_data == value_ff);

   // Read the head when idle so a pop or the first compare has data next cycle.
   assign rd_addr = (state_ff == ufifo_pkg::ST_IDLE) ? head_ff : scan_ptr_ff;

   ufifo_ram #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ufifo_pkg::ST_IDLE: begin
            if (req_take) begin
               if (count_ff == '0) begin
                  state_in = ufifo_pkg::ST_FINISH;
               end else if (req_payload.op == ufifo_pkg::OP_POP) begin
                  state_in = ufifo_pkg::ST_POP;
               end else begin
                  state_in = ufifo_pkg::ST_SCAN;
               end
            end
         end
         ufifo_pkg::ST_SCAN: begin
            if (match || (left_ff == CNT_W'(1))) begin
               state_in = ufifo_pkg::ST_FINISH;
            end
         end
         ufifo_pkg::ST_POP: begin
            state_in = ufifo_pkg::ST_FINISH;
         end
         ufifo_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = ufifo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ufifo_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath control
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      scan_ptr_in  = scan_ptr_ff;
      left_in      = left_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      popped_in    = popped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      case (state_ff)
         ufifo_pkg::ST_IDLE: begin
            if (req_take) begin
               op_in       = req_payload.op;
               value_in    = req_payload.value;
               popped_in   = '0;
               scan_ptr_in = next_slot(head_ff);
               left_in     = count_ff;
               if (count_ff == '0) begin
                  status_in = (req_payload.op == ufifo_pkg::OP_POP) ?
                              ufifo_pkg::STATUS_EMPTY : ufifo_pkg::STATUS_DONE;
               end else begin
                  status_in = ufifo_pkg::STATUS_DONE;
               end
            end
         end
         ufifo_pkg::ST_SCAN: begin
            // Compare the entry read last cycle; issue the next read.
            if (match) begin
               status_in = ufifo_pkg::STATUS_DUP;
            end else if (left_ff == CNT_W'(1)) begin
               status_in = (count_ff == FULL_COUNT) ?
                           ufifo_pkg::STATUS_FULL : ufifo_pkg::STATUS_DONE;
            end else begin
               scan_ptr_in = next_slot(scan_ptr_ff);
               left_in     = left_ff - CNT_W'(1);
            end
         end
         ufifo_pkg::ST_POP: begin
            popped_in = rd_data;
         end
         ufifo_pkg::ST_FINISH: begin
            if (out_free) begin
               if (status_ff == ufifo_pkg::STATUS_DONE) begin
                  if (op_ff == ufifo_pkg::OP_PUSH) begin
                     wr_en    = 1'b1;
                     tail_in  = next_slot(tail_ff);
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     head_in  = next_slot(head_ff);
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               rsp_valid_in        = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.popped_value = popped_ff;
               rsp_in.occupancy    = ufifo_pkg::OCC_W'(count_in);
            end
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ufifo_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      left_ff     <= left_in;
      op_ff       <= op_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      popped_ff   <= popped_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("held count exceeds depth");

   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_COUNT) |-> (head_ff == tail_ff))
      else $error("head and tail disagree with held count");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ufifo_pkg::ST_FINISH))
      else $error("response loaded outside the final step");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ufifo_pkg::ST_SCAN) |-> (left_ff != '0 && left_ff <= count_ff))
      else $error("compare walk out of range");
`endif

endmodule

/* bench/unique_value_fifo_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the duplicate-refusing value FIFO: directed table, then random traffic.
module unique_value_fifo_tb;

   localparam int DEPTH        = ufifo_pkg::DEPTH;
   localparam int RANDOM_ITEMS = 830;
   localparam int NUM_ROWS     = 24;
   localparam int POOL_SIZE    = 12;
   // Worst item: a compare walk over a full queue, the longest response stall and the
   // longest sender gap; take that over every item and allow several times more.
   localparam int CYCLE_LIMIT  = 600000;
   // Quiet window after the last response; a full-queue push is the slowest item.
   localparam int DRAIN_CYCLES = DEPTH + 24;

   // One row of the directed table. Where fixed_result is set, the response
   // is typed in; otherwise the shadow queue works it out.
   typedef struct packed {
      ufifo_pkg::op_type                    op;
      logic signed [ufifo_pkg::VALUE_W-1:0] value;
      logic                                 fixed_result;
      ufifo_pkg::rsp_type                   result;
   } table_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   ufifo_pkg::req_type req_payload;
   logic               rsp_valid;
   logic               rsp_stall;
   ufifo_pkg::rsp_type rsp_payload;

   // Shadow copy of the queue, advanced once per accepted transaction.
   logic signed [ufifo_pkg::VALUE_W-1:0] shadow_slots [DEPTH];
   int                                   shadow_head;
   int                                   shadow_tail;
   int                                   shadow_count;

   ufifo_pkg::rsp_type                   awaited_responses [$];
   logic signed [ufifo_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];
   int                                   status_tally [4];
   int                                   mismatch_count;
   int                                   cycle_count;
   logic                                 sender_burst;

   table_row_type directed_rows [NUM_ROWS] = '{
      // pop right after reset: nothing held
      '{ufifo_pkg::OP_POP,  32'sh0000_0000, 1'b1,
        '{ufifo_pkg::STATUS_EMPTY, 32'sh0000_0000, 5'd0}},
      // value extremes
      '{ufifo_pkg::OP_PUSH, 32'sh8000_0000, 1'b1,
        '{ufifo_pkg::STATUS_DONE,  32'sh0000_0000, 5'd1}},
      '{ufifo_pkg::OP_PUSH, 32'sh7FFF_FFFF, 1'b1,
        '{ufifo_pkg::STATUS_DONE,  32'sh0000_0000, 5'd2}},
      '{ufifo_pkg::OP_PUSH, 32'sh8000_0000, 1'b1,
        '{ufifo_pkg::STATUS_DUP,   32'sh0000_0000, 5'd2}},
      // differs from a held value in the lowest bit only
      '{ufifo_pkg::OP_PUSH, 32'sh8000_0001, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'sh0000_0000, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'shFFFF_FFFF, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'shFFFF_FFFE, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'sh5555_5555, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'shAAAA_AAAA, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'sh0000_0001, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'sh7FFF_FFFE, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'sh1234_5678, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'sh89AB_CDEF, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'sh0000_FFFF, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'shFFFF_0000, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'sh00FF_00FF, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'shFF00_FF00, 1'b0, '0},
      // queue full: a new value is refused, a held one reports duplicate first
      '{ufifo_pkg::OP_PUSH, 32'sh0000_0002, 1'b1,
        '{ufifo_pkg::STATUS_FULL,  32'sh0000_0000, 5'd16}},
      '{ufifo_pkg::OP_PUSH, 32'sh7FFF_FFFF, 1'b1,
        '{ufifo_pkg::STATUS_DUP,   32'sh0000_0000, 5'd16}},
      // pops return in push order; the value field is ignored
      '{ufifo_pkg::OP_POP,  32'shDEAD_BEEF, 1'b1,
        '{ufifo_pkg::STATUS_DONE,  32'sh8000_0000, 5'd15}},
      '{ufifo_pkg::OP_POP,  32'sh0000_0000, 1'b1,
        '{ufifo_pkg::STATUS_DONE,  32'sh7FFF_FFFF, 5'd14}},
      // a popped value may come back; one still held may not
      '{ufifo_pkg::OP_PUSH, 32'sh8000_0000, 1'b0, '0},
      '{ufifo_pkg::OP_PUSH, 32'sh8000_0001, 1'b0, '0}
   };

   unique_value_fifo i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Apply one transaction to the shadow queue and return the response it owes.
   // The duplicate search runs before the full check, so a held value on a full
   // queue reports duplicate.
   function automatic ufifo_pkg::rsp_type apply_to_shadow(input ufifo_pkg::req_type item);
      ufifo_pkg::rsp_type result;
      int                 slot;
      logic               found;
      result = '{status: ufifo_pkg::STATUS_DONE, popped_value: '0, occupancy: '0};
      found  = 1'b0;
      if (item.op == ufifo_pkg::OP_PUSH) begin
         slot = shadow_head;
         for (int k = 0; k < shadow_count; k++) begin
            if (shadow_slots[slot] == item.value) found = 1'b1;
            slot = (slot + 1) % DEPTH;
         end
         if (found) begin
            result.status = ufifo_pkg::STATUS_DUP;
         end else if (shadow_count >= DEPTH) begin
            result.status = ufifo_pkg::STATUS_FULL;
         end else begin
            shadow_slots[shadow_tail] = item.value;
            shadow_tail  = (shadow_tail + 1) % DEPTH;
            shadow_count = shadow_count + 1;
         end
      end else begin
         if (shadow_count == 0) begin
            result.status = ufifo_pkg::STATUS_EMPTY;
         end else begin
            result.popped_value = shadow_slots[shadow_head];
            shadow_head  = (shadow_head + 1) % DEPTH;
            shadow_count = shadow_count - 1;
         end
      end
      result.occupancy = shadow_count[ufifo_pkg::OCC_W-1:0];
      status_tally[int'(result.status)]++;
      return result;
   endfunction

   // Value mix: a held value (forces a duplicate), a small reused pool
   // (repeats after pops), or fully random bits.
   function automatic logic signed [ufifo_pkg::VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35 && shadow_count > 0)
         return shadow_slots[(shadow_head + $urandom_range(0, shadow_count - 1)) % DEPTH];
      if (r < 75) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom();
   endfunction

   // Drive one transaction at the falling edge and hold it until accepted.
   // Valid drops only during a gap, so each step sees at most one assignment.
   task automatic send_item(input ufifo_pkg::req_type item, input logic fixed_result,
                            input ufifo_pkg::rsp_type fixed_rsp);
      ufifo_pkg::rsp_type predicted;
      int                 gap;
      gap = sender_burst ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      predicted = apply_to_shadow(item);
      awaited_responses.push_back(fixed_result ? fixed_rsp : predicted);
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
   endtask

   // Response side: stall in random runs, with long stall-free stretches now and then.
   initial begin
      int free_left;
      int hold_left;
      rsp_stall = 1'b0;
      free_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left--;
         end else if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
            free_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : pick_gap();
            hold_left = pick_gap();
         end
      end
   end

   // Check every accepted response against the oldest outstanding transaction,
   // and bound the run.
   always @(posedge clock) begin
      ufifo_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, awaited_responses.size());
         $display("end of test: mismatches");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_responses.size() == 0) begin
            $error("response with no transaction outstanding: status %0d value %0d occ %0d",
                   rsp_payload.status, rsp_payload.popped_value, rsp_payload.occupancy);
            mismatch_count++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               mismatch_count++;
            end
            if (rsp_payload.popped_value !== want.popped_value) begin
               $error("popped_value: expected %0d, got %0d",
                      want.popped_value, rsp_payload.popped_value);
               mismatch_count++;
            end
            if (rsp_payload.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d",
                      want.occupancy, rsp_payload.occupancy);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      ufifo_pkg::req_type item;
      int                 push_pct;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      cycle_count    = 0;
      mismatch_count = 0;
      sender_burst   = 1'b0;
      shadow_head    = 0;
      shadow_tail    = 0;
      shadow_count   = 0;
      push_pct       = 50;
      for (int s = 0; s < 4; s++) status_tally[s] = 0;
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7FFF_FFFF;
      value_pool[2] = 32'sh0000_0000;
      value_pool[3] = 32'shFFFF_FFFF;
      for (int p = 4; p < POOL_SIZE; p++) value_pool[p] = $urandom();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: empty pop, extremes, fill to full, full and
      // duplicate refusals, ordered pops.
      for (int i = 0; i < NUM_ROWS; i++) begin
         item.op    = directed_rows[i].op;
         item.value = directed_rows[i].value;
         send_item(item, directed_rows[i].fixed_result, directed_rows[i].result);
      end

      // Random traffic in phases that lean toward filling, balancing or
      // draining, so the queue keeps hitting full and empty and the pointers wrap.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 85;
               1: push_pct = 50;
               default: push_pct = 15;
            endcase
            sender_burst = ($urandom_range(0, 3) == 0);
         end
         if (n == RANDOM_ITEMS / 2) pause_until_drained();
         item.op    = ($urandom_range(0, 99) < push_pct) ? ufifo_pkg::OP_PUSH :
                                                            ufifo_pkg::OP_POP;
         item.value = pick_value();
         send_item(item, 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d transactions (%0d directed): %0d completed, %0d duplicates refused,",
               NUM_ROWS + RANDOM_ITEMS, NUM_ROWS,
               status_tally[int'(ufifo_pkg::STATUS_DONE)],
               status_tally[int'(ufifo_pkg::STATUS_DUP)]);
      $display("%0d pushes refused while full, %0d pops on an empty queue; %0d field mismatches.",
               status_tally[int'(ufifo_pkg::STATUS_FULL)],
               status_tally[int'(ufifo_pkg::STATUS_EMPTY)],
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* unique_value_fifo.f */
rtl/ufifo_pkg.sv
rtl/ufifo_ram.sv
rtl/unique_value_fifo.sv
bench/unique_value_fifo_tb.sv
